>>> sv/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg: shared types and constants for the sensor window average alarm
// Status codes, register indexes, table entry layout and the reciprocal
// used to divide the window sum by the window length.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int WINDOW_LEN  = 5;
    localparam int SLOT_W      = 3;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = SAMPLE_W + 3;   // five 16-bit samples
    localparam int MAG_W       = SUM_W - 1;      // |sum| <= 163840 < 2**18
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 18;
    // floor(n * 52429 / 2**18) == floor(n / 5) for all n < 2**18
    localparam logic [RECIP_W-1:0] RECIP_5 = 16'd52429;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT = 2'd1;

    localparam logic signed [15:0] LOW_LIMIT_RST  = 16'sd1500;
    localparam logic signed [15:0] HIGH_LIMIT_RST = 16'sd2500;

    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] ST_IN_RANGE = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_HOT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_COLD = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FILLING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STORED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd6;

    typedef struct packed {
        logic [15:0]       sensor;
        logic [15:0]       room;
        logic [SLOT_W-1:0] slot;
        logic              full;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic acc_en;
        logic mul_en;
    } mean_ctrl_t;

endpackage

>>> sv/swa_table.sv
// ----------------------------------------------------------------------------
// swa_table: sensor map table
// One entry per mapped sensor: sensor id, room id, ring write slot and the
// window-full flag. One write port, one registered read port.
// ----------------------------------------------------------------------------
module swa_table
    import swa_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
)(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/swa_window.sv
// ----------------------------------------------------------------------------
// swa_window: sample ring storage
// Five slots per table entry, flat addressed as entry * 5 + slot.
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module swa_window
    import swa_pkg::*;
#(
    parameter int DEPTH  = 160,
    parameter int ADDR_W = 8
)(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/swa_mean.sv
// ----------------------------------------------------------------------------
// swa_mean: window accumulator and divide-by-five unit
// Accumulates one sample per beat, then divides the magnitude by five with a
// reciprocal multiply and restores the sign (truncation toward zero).
// ----------------------------------------------------------------------------
module swa_mean
    import swa_pkg::*;
(
    input  logic                       clk,
    input  mean_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic signed [SAMPLE_W-1:0] avg
);

    logic signed [SUM_W-1:0]         acc_reg;
    logic [MAG_W+RECIP_W-1:0]        prod_reg;
    logic                            neg_reg;
    logic [SUM_W-1:0]                mag_full;
    logic [MAG_W-1:0]                mag;
    logic [SAMPLE_W-1:0]             quot;

    assign mag_full = acc_reg[SUM_W-1] ? -acc_reg : acc_reg;
    assign mag      = mag_full[MAG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + SUM_W'(sample);
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(RECIP_5);
            neg_reg  <= acc_reg[SUM_W-1];
        end
    end

    assign quot = prod_reg[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
    assign avg  = neg_reg ? -$signed(quot) : $signed(quot);

endmodule

>>> sv/sensor_window_average_alarm.sv
// ----------------------------------------------------------------------------
// sensor_window_average_alarm: per-sensor moving average with alarm limits
// Maps sensor ids to rooms and reports the five-sample window mean of each
// mapped sensor against configurable low and high limits.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): command 0 appends a map entry
//    sensor_id -> room_id; command 1 delivers a sample for sensor_id.
//  - Output channel (out_valid/out_ready): exactly one result beat per input
//    beat, carrying status, the echoed sensor id, the room and the mean.
//  - Config channel (cfg_valid/cfg_ready): index 0 low limit, 1 high limit;
//    other indexes are dropped. cfg_ready is always high.
//  - One item at a time. The id search reads one table entry per cycle
//    over the mapped entries; when a mean is computed, the five-slot sum
//    runs through one accumulator, then one reciprocal multiply. An
//    unmapped or still filling sample skips the sum and the multiply.
//  - The result sits in an output register; the next input beat is accepted
//    while it waits. If the receiver stalls, the block holds its following
//    result until the register frees up, and takes no new beat meanwhile.
//  - Reset empties the table (fill count to zero) and loads the default
//    limits 1500 and 2500. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sensor_window_average_alarm
    import swa_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        command,
    input  logic [15:0]                 sensor_id,
    input  logic [15:0]                 room_id,
    input  logic signed [15:0]          sample_value,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [STATUS_W-1:0]         status,
    output logic [15:0]                 sensor_id_out,
    output logic [15:0]                 room_out,
    output logic signed [15:0]          average,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [15:0]                 cfg_data
);

    localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int WIN_DEPTH = TABLE_DEPTH * WINDOW_LEN;
    localparam int WA_W      = $clog2(WIN_DEPTH);
    localparam int K_W       = $clog2(WINDOW_LEN + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MAP    = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;

    // captured input beat
    logic [15:0]                sid_reg;
    logic [15:0]                rid_reg;
    logic signed [15:0]         smp_reg;

    // limits
    logic signed [15:0]         low_reg;
    logic signed [15:0]         high_reg;

    // table fill count: entries below it are valid
    logic [CNT_W-1:0]           count_reg;

    // search pipeline
    logic [CNT_W-1:0]           scan_reg;
    logic                       pend_reg;
    logic [IDX_W-1:0]           pidx_reg;

    // matched entry
    logic [IDX_W-1:0]           hit_idx_reg;
    logic [15:0]                hit_room_reg;
    logic [SLOT_W-1:0]          hit_slot_reg;
    logic                       hit_full_reg;
    logic [WA_W-1:0]            wbase_reg;

    // window sum
    logic [K_W-1:0]             k_reg;
    logic                       wpend_reg;

    // pending result
    logic [STATUS_W-1:0]        res_status_reg;
    logic [15:0]                res_room_reg;
    logic signed [15:0]         res_avg_reg;

    // output register
    logic                       out_valid_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic [15:0]                sid_out_reg;
    logic [15:0]                room_out_reg;
    logic signed [15:0]         avg_out_reg;

    // table port
    logic                       tbl_wr_en;
    logic [IDX_W-1:0]           tbl_wr_addr;
    entry_t                     tbl_wr_data;
    entry_t                     tbl_rd_data;

    // window port
    logic                       win_wr_en;
    logic [WA_W-1:0]            win_wr_addr;
    logic [WA_W-1:0]            win_rd_addr;
    logic signed [15:0]         win_rd_data;

    // mean unit
    mean_ctrl_t                 mean_ctrl;
    logic signed [15:0]         mean_avg;

    logic                       in_fire;
    logic                       out_free;
    logic                       table_full;
    logic                       issue;
    logic                       match;
    logic                       miss;
    logic [IDX_W+2:0]           wbase_full;
    logic [SLOT_W-1:0]          slot_eff;
    logic                       slot_last;
    logic [SLOT_W-1:0]          slot_nx;
    logic                       full_new;
    logic                       sum_issue;
    logic                       sum_done;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign cfg_ready  = 1'b1;
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));

    // search: one table read issued per cycle, each compared in the cycle after its issue
    assign issue = (state_reg == S_SEARCH) && (scan_reg < count_reg);
    assign match = (state_reg == S_SEARCH) && pend_reg && (tbl_rd_data.sensor == sid_reg);
    assign miss  = (state_reg == S_SEARCH) && !pend_reg && !issue;

    // ring base address = entry * 5
    assign wbase_full = {1'b0, pidx_reg, 2'b00} + {3'b000, pidx_reg};

    // ring slot update
    assign slot_eff  = (hit_slot_reg >= SLOT_W'(WINDOW_LEN)) ? '0 : hit_slot_reg;
    assign slot_last = (slot_eff == SLOT_W'(WINDOW_LEN - 1));
    assign slot_nx   = slot_last ? '0 : slot_eff + 1'b1;
    assign full_new  = hit_full_reg || slot_last;

    assign sum_issue = (state_reg == S_SUM) && (k_reg < K_W'(WINDOW_LEN));
    assign sum_done  = (state_reg == S_SUM) && !sum_issue && !wpend_reg;

    // table write: append on map while not full, write-back of slot and full on a matched sample
    always_comb
    begin
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = hit_idx_reg;
        tbl_wr_data = '{sensor: sid_reg, room: hit_room_reg, slot: slot_nx, full: full_new};
        if (state_reg == S_MAP && !table_full)
        begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = count_reg[IDX_W-1:0];
            tbl_wr_data = '{sensor: sid_reg, room: rid_reg, slot: '0, full: 1'b0};
        end
        else if (state_reg == S_UPD)
        begin
            tbl_wr_en = 1'b1;
        end
    end

    assign win_wr_en   = (state_reg == S_UPD);
    assign win_wr_addr = wbase_reg + WA_W'(slot_eff);
    assign win_rd_addr = wbase_reg + WA_W'(k_reg);

    assign mean_ctrl.clear  = (state_reg == S_UPD);
    assign mean_ctrl.acc_en = wpend_reg;
    assign mean_ctrl.mul_en = (state_reg == S_MUL);

    swa_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .rd_data (tbl_rd_data)
    );

    swa_window #(
        .DEPTH  (WIN_DEPTH),
        .ADDR_W (WA_W)
    ) u_window (
        .clk     (clk),
        .wr_en   (win_wr_en),
        .wr_addr (win_wr_addr),
        .wr_data (smp_reg),
        .rd_addr (win_rd_addr),
        .rd_data (win_rd_data)
    );

    swa_mean u_mean (
        .clk    (clk),
        .ctrl   (mean_ctrl),
        .sample (win_rd_data),
        .avg    (mean_avg)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = command ? S_SEARCH : S_MAP;
                end
            end
            S_MAP:    state_next = S_DONE;
            S_SEARCH:
            begin
                if (match)
                begin
                    state_next = S_UPD;
                end
                else if (miss)
                begin
                    state_next = S_DONE;
                end
            end
            S_UPD:    state_next = full_new ? S_SUM : S_DONE;
            S_SUM:
            begin
                if (sum_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:    state_next = S_FIN;
            S_FIN:    state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            low_reg       <= LOW_LIMIT_RST;
            high_reg      <= HIGH_LIMIT_RST;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            wpend_reg     <= 1'b0;
            scan_reg      <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LOW_LIMIT)
                begin
                    low_reg <= $signed(cfg_data);
                end
                else if (cfg_index == REG_HIGH_LIMIT)
                begin
                    high_reg <= $signed(cfg_data);
                end
            end

            if (state_reg == S_MAP && !table_full)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (in_fire)
            begin
                scan_reg <= '0;
            end
            else if (issue)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            pend_reg <= issue;

            if (state_reg == S_UPD)
            begin
                k_reg <= '0;
            end
            else if (sum_issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            wpend_reg <= sum_issue;

            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sid_reg <= sensor_id;
            rid_reg <= room_id;
            smp_reg <= sample_value;
        end

        pidx_reg <= scan_reg[IDX_W-1:0];

        if (match)
        begin
            hit_idx_reg  <= pidx_reg;
            hit_room_reg <= tbl_rd_data.room;
            hit_slot_reg <= tbl_rd_data.slot;
            hit_full_reg <= tbl_rd_data.full;
            wbase_reg    <= wbase_full[WA_W-1:0];
        end

        if (state_reg == S_MAP)
        begin
            res_status_reg <= table_full ? ST_FULL : ST_STORED;
            res_room_reg   <= table_full ? '0 : rid_reg;
            res_avg_reg    <= '0;
        end
        else if (miss)
        begin
            res_status_reg <= ST_UNMAPPED;
            res_room_reg   <= '0;
            res_avg_reg    <= '0;
        end
        else if (state_reg == S_UPD)
        begin
            res_status_reg <= ST_FILLING;
            res_room_reg   <= hit_room_reg;
            res_avg_reg    <= '0;
        end
        else if (state_reg == S_FIN)
        begin
            // too hot wins when both limits are crossed
            if (mean_avg > high_reg)
            begin
                res_status_reg <= ST_TOO_HOT;
            end
            else if (mean_avg < low_reg)
            begin
                res_status_reg <= ST_TOO_COLD;
            end
            else
            begin
                res_status_reg <= ST_IN_RANGE;
            end
            res_avg_reg <= mean_avg;
        end

        if (state_reg == S_DONE && out_free)
        begin
            status_reg   <= res_status_reg;
            sid_out_reg  <= sid_reg;
            room_out_reg <= res_room_reg;
            avg_out_reg  <= res_avg_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign sensor_id_out = sid_out_reg;
    assign room_out      = room_out_reg;
    assign average       = avg_out_reg;

endmodule

>>> sv/swa_checker.sv
// ----------------------------------------------------------------------------
// swa_checker: port-level checks for the sensor window average alarm
// Watches the channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module swa_checker
    import swa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [STATUS_W-1:0] status,
    input  logic [15:0]         room_out,
    input  logic signed [15:0]  average
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(average))
        else $error("result beat changed while stalled");

    // one item at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_FULL)
        else $error("undefined status code");

    // mean only reported with an alarm or in-range status
    a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FILLING || status == ST_UNMAPPED ||
                      status == ST_STORED || status == ST_FULL) |-> average == 16'sd0)
        else $error("nonzero average without a mean");

    a_room_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_UNMAPPED || status == ST_FULL) |-> room_out == 16'd0)
        else $error("room reported for unmapped or full");

endmodule

bind sensor_window_average_alarm swa_checker u_swa_checker (.*);

>>> tb/sensor_window_average_alarm_tb.sv
// ----------------------------------------------------------------------------
// sensor_window_average_alarm_tb: self-checking regression for the alarm block
// Drives map and sample beats through valid/ready with random gaps on both
// sides and keeps its own model of the sensor table, the five-slot windows
// and the limits. Every result beat is checked field by field, in order.
// ----------------------------------------------------------------------------
module sensor_window_average_alarm_tb;
    import swa_pkg::*;

    localparam int MAP_DEPTH   = 32;
    localparam int POOL_SIZE   = 40;
    localparam int CYCLE_LIMIT = 800000;
    localparam int MAX_REPORTS = 10;

    // input command codes
    localparam logic CMD_MAP    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // config indexes with no register behind them, written to check they drop
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic               command;
        logic [15:0]        sensor;
        logic [15:0]        room;
        logic signed [15:0] value;
    } reading_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [15:0]         sensor;
        logic [15:0]         room;
        logic signed [15:0]  mean;
    } report_t;

    // ------------------------------------------------------------------------
    // Ports. Everything the testbench drives starts at a known value.
    // ------------------------------------------------------------------------
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic                   command      = CMD_MAP;
    logic [15:0]            sensor_id    = '0;
    logic [15:0]            room_id      = '0;
    logic signed [15:0]     sample_value = '0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [15:0]            sensor_id_out;
    logic [15:0]            room_out;
    logic signed [15:0]     average;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [15:0]            cfg_data     = '0;

    sensor_window_average_alarm #(
        .TABLE_DEPTH   (MAP_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .sensor_id     (sensor_id),
        .room_id       (room_id),
        .sample_value  (sample_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .sensor_id_out (sensor_id_out),
        .room_out      (room_out),
        .average       (average),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // Model state: sensor table, per-entry sample rings, alarm limits.
    // Only entries and slots already written are ever read, so the model
    // needs no reset value for them beyond what the block defines.
    // ------------------------------------------------------------------------
    logic               map_used   [MAP_DEPTH];
    logic [15:0]        map_sensor [MAP_DEPTH];
    logic [15:0]        map_room   [MAP_DEPTH];
    logic signed [15:0] ring       [MAP_DEPTH][WINDOW_LEN];
    int                 ring_pos   [MAP_DEPTH];
    logic               ring_full  [MAP_DEPTH];
    int                 map_count;
    logic signed [15:0] lim_low;
    logic signed [15:0] lim_high;

    reading_t    readings_to_send[$];
    report_t     pending_reports[$];
    logic [15:0] sensor_pool[POOL_SIZE];

    int   beats_offered  = 0;   // beats raised on the input channel
    int   beats_in       = 0;   // beats accepted on the input channel
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    logic pressure_go    = 1'b0;
    logic rx_hold        = 1'b0;

    initial
    begin
        for (int e = 0; e < MAP_DEPTH; e++)
        begin
            map_used[e]  = 1'b0;
            ring_pos[e]  = 0;
            ring_full[e] = 1'b0;
        end
        map_count = 0;
        lim_low   = LOW_LIMIT_RST;
        lim_high  = HIGH_LIMIT_RST;
    end

    // Result of one accepted beat; updates the model as the block would.
    function automatic report_t compute_report(input logic cmd, input logic [15:0] sid,
                                               input logic [15:0] rid,
                                               input logic signed [15:0] val);
        report_t r;
        int      hit;
        int      pos;
        int      total;
        int      mean_i;
        r.status = ST_UNMAPPED;
        r.sensor = sid;
        r.room   = '0;
        r.mean   = '0;
        if (cmd == CMD_MAP)
        begin
            if (map_count < MAP_DEPTH)
            begin
                map_used[map_count]   = 1'b1;
                map_sensor[map_count] = sid;
                map_room[map_count]   = rid;
                ring_pos[map_count]   = 0;
                ring_full[map_count]  = 1'b0;
                map_count++;
                r.status = ST_STORED;
                r.room   = rid;
            end
            else
                r.status = ST_FULL;
        end
        else
        begin
            // first matching entry wins; duplicates behind it are never hit
            hit = -1;
            for (int e = 0; e < MAP_DEPTH; e++)
                if (hit < 0 && map_used[e] && map_sensor[e] == sid)
                    hit = e;
            if (hit >= 0)
            begin
                pos            = ring_pos[hit];
                ring[hit][pos] = val;
                if (pos == WINDOW_LEN - 1)
                    ring_full[hit] = 1'b1;
                ring_pos[hit] = (pos + 1) % WINDOW_LEN;
                r.room        = map_room[hit];
                if (ring_full[hit])
                begin
                    total = 0;
                    for (int k = 0; k < WINDOW_LEN; k++)
                        total += int'(ring[hit][k]);
                    mean_i = total / WINDOW_LEN;   // truncates toward zero
                    r.mean = mean_i[15:0];
                    // too hot is checked first, so it wins when limits cross
                    if (mean_i > int'(lim_high))
                        r.status = ST_TOO_HOT;
                    else if (mean_i < int'(lim_low))
                        r.status = ST_TOO_COLD;
                    else
                        r.status = ST_IN_RANGE;
                end
                else
                    r.status = ST_FILLING;
            end
        end
        return r;
    endfunction

    function automatic void queue_reading(input logic cmd, input logic [15:0] sid,
                                          input logic [15:0] rid,
                                          input logic signed [15:0] val);
        reading_t b;
        b.command = cmd;
        b.sensor  = sid;
        b.room    = rid;
        b.value   = val;
        readings_to_send.push_back(b);
    endfunction

    // Random beat: mostly samples for mapped sensors, with values clustered
    // around the current limits so means land on both sides of them.
    function automatic void queue_random(input int count);
        int          roll;
        int          v;
        logic [15:0] sid;
        logic        cmd;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            cmd  = (roll < 6) ? CMD_MAP : CMD_SAMPLE;
            if (roll < 6)
                sid = sensor_pool[$urandom_range(31)];
            else if (roll < 14)
                sid = sensor_pool[32 + $urandom_range(7)];   // likely unmapped
            else
                sid = sensor_pool[$urandom_range(31)];
            if ($urandom_range(9) < 4)
                v = int'($signed(16'($urandom)));
            else
            begin
                v = $urandom_range(1) ? int'(lim_low) : int'(lim_high);
                v = v + int'($urandom_range(600)) - 300;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
            end
            queue_reading(cmd, sid, 16'($urandom), v[15:0]);
        end
    endfunction

    // Block is idle once nothing is queued, offered or outstanding.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (readings_to_send.size() != 0 || in_valid || pending_reports.size() != 0);
    endtask

    task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_LOW_LIMIT)
            lim_low = data;
        else if (idx == REG_HIGH_LIMIT)
            lim_high = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Input driver: holds a beat until accepted, otherwise idles at random
    // or raises the next queued beat. Changes only at the falling edge.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_readings
        reading_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && beats_in != beats_offered)
            ;   // still waiting for in_ready, keep payload steady
        else if (readings_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            nxt           = readings_to_send.pop_front();
            in_valid     <= 1'b1;
            command      <= nxt.command;
            sensor_id    <= nxt.sensor;
            room_id      <= nxt.room;
            sample_value <= nxt.value;
            beats_offered <= beats_offered + 1;
        end
        else
            in_valid <= 1'b0;
    end

    // Output side: random back-pressure, or a long hold while pressure is on.
    always @(negedge clk)
    begin : drive_out_ready
        if (!rst_n || rx_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver stall, counted here so the sender keeps offering beats
    // and the block fills its output register and stops taking input.
    initial
    begin : receiver_hold
        wait (pressure_go);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(negedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Results are checked
    // before new expectations are queued; a result never belongs to a beat
    // accepted on the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        report_t want;
        report_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.status = status;
                got.sensor = sensor_id_out;
                got.room   = room_out;
                got.mean   = average;
                if (pending_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result beat: status %0d sensor %h room %h avg %0d",
                                 got.status, got.sensor, got.room, got.mean);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $write("mismatch: expected status %0d sensor %h room %h avg %0d",
                                   want.status, want.sensor, want.room, want.mean);
                            $display(", got status %0d sensor %h room %h avg %0d",
                                     got.status, got.sensor, got.room, got.mean);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pending_reports.push_back(compute_report(command, sensor_id, room_id,
                                                         sample_value));
                beats_in <= beats_in + 1;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sensor_window_average_alarm regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence: directed beats at reset limits, then random phases under
    // several limit settings, limits always changed with the block idle.
    // ------------------------------------------------------------------------
    initial
    begin : run_sequence
        int lo;
        int hi;
        int t;
        sensor_pool[0] = 16'h0000;
        sensor_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            sensor_pool[i] = 16'($urandom);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 84;

        // sample for a sensor nobody mapped
        queue_reading(CMD_SAMPLE, 16'h1234, 16'hFFFF, 16'sh7FFF);
        // map both id extremes
        queue_reading(CMD_MAP, 16'hFFFF, 16'hFFFF, 16'sh8000);
        queue_reading(CMD_MAP, 16'h0000, 16'h0000, 16'sh7FFF);
        // fill a window at the top value, then walk it to the bottom value
        for (int i = 0; i < WINDOW_LEN; i++)
            queue_reading(CMD_SAMPLE, 16'hFFFF, 16'h0000, 16'sh7FFF);
        for (int i = 0; i < WINDOW_LEN; i++)
            queue_reading(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'sh8000);
        // duplicate map: lookups still go to the first entry for sensor 0
        queue_reading(CMD_MAP, 16'h0000, 16'h5A5A, 16'sh0000);
        for (int i = 0; i < WINDOW_LEN - 1; i++)
            queue_reading(CMD_SAMPLE, 16'h0000, 16'hA5A5, 16'sd2000);
        queue_reading(CMD_SAMPLE, 16'h0000, 16'hA5A5, 16'sd2002);   // mean truncates
        queue_reading(CMD_SAMPLE, 16'h0000, 16'h0000, -16'sd7);
        queue_random(200);
        wait_drained();

        // widest limits: everything lands in range
        write_limit(REG_LOW_LIMIT, 16'h8000);
        write_limit(REG_HIGH_LIMIT, 16'h7FFF);
        queue_random(200);
        wait_drained();

        send_idle_pct = 84;
        recv_idle_pct = 12;

        // crossed limits: too hot has priority
        write_limit(REG_LOW_LIMIT, 16'h7FFF);
        write_limit(REG_HIGH_LIMIT, 16'h8000);
        queue_random(200);
        wait_drained();

        // random ordered limits, plus writes to indexes with no register
        lo = int'($signed(16'($urandom)));
        hi = int'($signed(16'($urandom)));
        if (lo > hi)
        begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        write_limit(REG_SPARE_2, 16'($urandom));
        write_limit(REG_LOW_LIMIT, lo[15:0]);
        write_limit(REG_HIGH_LIMIT, hi[15:0]);
        write_limit(REG_SPARE_3, 16'($urandom));
        queue_random(200);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;

        // equal limits at zero, with the long receiver stall in this phase
        write_limit(REG_LOW_LIMIT, 16'h0000);
        write_limit(REG_HIGH_LIMIT, 16'h0000);
        queue_random(200);
        pressure_go = 1'b1;
        wait_drained();

        write_limit(REG_LOW_LIMIT, -16'sd500);
        write_limit(REG_HIGH_LIMIT, 16'sd500);
        queue_random(200);
        wait_drained();

        // catch any stray result beats
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("sensor_window_average_alarm regression: pass");
        else
            $display("sensor_window_average_alarm regression: fail");
        $finish;
    end

endmodule

>>> files.f
sv/swa_pkg.sv
sv/swa_table.sv
sv/swa_window.sv
sv/swa_mean.sv
sv/sensor_window_average_alarm.sv
sv/swa_checker.sv
tb/sensor_window_average_alarm_tb.sv
